[rtl/core/gic_pkg.sv]
// Shared types and constants for the gamepad input conditioner.
// Used by the channel interfaces and by every module under rtl/core.
package gic_pkg;

    // Field widths
    localparam int BTN_W    = 16;
    localparam int VEC_W    = 20;
    localparam int AXIS_W   = 9;
    localparam int RAW_W    = 8;
    localparam int CIDX_W   = 3;
    localparam int CDATA_W  = 8;

    // Virtual direction bit positions in the button vector
    localparam int BIT_RIGHT = 16;
    localparam int BIT_LEFT  = 17;
    localparam int BIT_DOWN  = 18;
    localparam int BIT_UP    = 19;

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_REVERSE_ANALOG      = 3'd0,
        CFG_DEAD_ZONE           = 3'd1,
        CFG_DIRECTION_THRESHOLD = 3'd2,
        CFG_FLICK_MARGIN        = 3'd3,
        CFG_REPEAT_DELAY        = 3'd4,
        CFG_REPEAT_INTERVAL     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic       reverse_analog;
        logic [6:0] dead_zone;
        logic [6:0] direction_threshold;
        logic [7:0] flick_margin;
        logic [7:0] repeat_delay;
        logic [7:0] repeat_interval;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reverse_analog:      1'b0,
        dead_zone:           7'd4,
        direction_threshold: 7'd32,
        flick_margin:        8'd16,
        repeat_delay:        8'd15,
        repeat_interval:     8'd4
    };

    // Classified sample passed from the front end to the back end
    typedef struct packed {
        logic [BTN_W-1:0]         buttons;
        logic signed [AXIS_W-1:0] stick_x;
        logic signed [AXIS_W-1:0] stick_y;
        logic                     x_pos;
        logic                     x_neg;
        logic                     y_pos;
        logic                     y_neg;
    } t_item;

endpackage

[rtl/core/gic_if.sv]
// Valid/ready channel interfaces of the gamepad input conditioner:
// pad sample request, conditioned result request, configuration write.
// Depends on gic_pkg for field widths.
interface gic_in_if import gic_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [BTN_W-1:0]        raw_buttons;
    logic signed [RAW_W-1:0] raw_stick_x;
    logic signed [RAW_W-1:0] raw_stick_y;

    modport source (output valid, raw_buttons, raw_stick_x, raw_stick_y, input ready);
    modport sink   (input valid, raw_buttons, raw_stick_x, raw_stick_y, output ready);
endinterface

interface gic_out_if import gic_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [VEC_W-1:0]         current_buttons;
    logic [VEC_W-1:0]         pressed_buttons;
    logic [VEC_W-1:0]         repeat_buttons;
    logic signed [AXIS_W-1:0] stick_x_out;
    logic signed [AXIS_W-1:0] stick_y_out;

    modport source (output valid, current_buttons, pressed_buttons, repeat_buttons,
                    stick_x_out, stick_y_out, input ready);
    modport sink   (input valid, current_buttons, pressed_buttons, repeat_buttons,
                    stick_x_out, stick_y_out, output ready);
endinterface

interface gic_cfg_if import gic_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/gic_front.sv]
// Front end: accepts pad samples, applies dead zone and reversal, and
// classifies each axis against the direction threshold. Depends on gic_pkg, gic_if.
module gic_front import gic_pkg::*; (
    input  t_cfg           i_cfg,
    gic_in_if.sink         i_in,
    output logic           o_wr_valid,
    input  logic           i_wr_ready,
    output t_item          o_wr_item
);

    // Shrink an axis toward zero, clamp at zero, optionally negate
    function automatic logic signed [AXIS_W-1:0] f_condition(
        input logic signed [RAW_W-1:0] a,
        input logic [6:0]              dz,
        input logic                    rev
    );
        logic signed [9:0] a10;
        logic signed [9:0] dz10;
        logic signed [9:0] t;
        a10  = {{2{a[RAW_W-1]}}, a};
        dz10 = {3'b000, dz};
        t    = '0;
        if (a10 > 0) begin
            t = a10 - dz10;
            if (t < 0) t = '0;
        end else if (a10 < 0) begin
            t = a10 + dz10;
            if (t > 0) t = '0;
        end
        if (rev) t = -t;
        return t[AXIS_W-1:0];
    endfunction

    logic signed [AXIS_W-1:0] s_x;
    logic signed [AXIS_W-1:0] s_y;
    logic signed [9:0]        thr_pos;
    logic signed [9:0]        thr_neg;
    logic signed [9:0]        x10;
    logic signed [9:0]        y10;

    // Condition both axes
    assign s_x = f_condition(i_in.raw_stick_x, i_cfg.dead_zone, i_cfg.reverse_analog);
    assign s_y = f_condition(i_in.raw_stick_y, i_cfg.dead_zone, i_cfg.reverse_analog);

    // Classify against the threshold
    assign thr_pos = {3'b000, i_cfg.direction_threshold};
    assign thr_neg = -thr_pos;
    assign x10     = {s_x[AXIS_W-1], s_x};
    assign y10     = {s_y[AXIS_W-1], s_y};

    always_comb begin
        o_wr_item.buttons = i_in.raw_buttons;
        o_wr_item.stick_x = s_x;
        o_wr_item.stick_y = s_y;
        o_wr_item.x_pos   = x10 > thr_pos;
        o_wr_item.x_neg   = x10 < thr_neg;
        o_wr_item.y_pos   = y10 > thr_pos;
        o_wr_item.y_neg   = y10 < thr_neg;
    end

    // Pass the request straight into the queue
    assign o_wr_valid = i_in.valid;
    assign i_in.ready = i_wr_ready;

endmodule

[rtl/core/gic_queue.sv]
// Two-entry queue decoupling the front end from the back end.
// Depends on gic_pkg for the item type.
module gic_queue import gic_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    output logic  o_wr_ready,
    input  t_item i_wr_item,
    output logic  o_rd_valid,
    input  logic  i_rd_ready,
    output t_item o_rd_item
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic [1:0]  n_count;
    logic        push;
    logic        pop;

    assign o_wr_ready = (r_count != 2'd2);
    assign o_rd_valid = (r_count != 2'd0);
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (push && !pop) n_count = r_count + 2'd1;
        if (pop && !push) n_count = r_count - 2'd1;
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr_ptr] <= i_wr_item;
    end

endmodule

[rtl/core/gic_back.sv]
// Back end: peak tracking, flick re-trigger, press edges and typematic
// repeat, with the result register. Depends on gic_pkg, gic_if.
module gic_back import gic_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_rd_valid,
    output logic    o_rd_ready,
    input  t_item   i_rd_item,
    gic_out_if.source o_out
);

    typedef struct packed {
        logic                     pos;
        logic                     neg;
        logic signed [AXIS_W-1:0] peak;
        logic                     rebound;
    } t_axis_upd;

    // Direction bits, peak and rebound update of one axis
    function automatic t_axis_upd f_axis(
        input logic signed [AXIS_W-1:0] s,
        input logic                     is_pos,
        input logic                     is_neg,
        input logic                     prev_pos,
        input logic                     prev_neg,
        input logic signed [AXIS_W-1:0] peak,
        input logic                     reb,
        input logic [7:0]               margin
    );
        t_axis_upd                u;
        logic signed [AXIS_W-1:0] tp;
        logic                     tr;
        logic signed [10:0]       d_up;
        logic signed [10:0]       d_dn;
        logic signed [10:0]       m11;
        tp    = peak;
        tr    = reb;
        u.pos = 1'b0;
        u.neg = 1'b0;
        // Track the peak
        if (is_pos) begin
            u.pos = 1'b1;
            if (!prev_pos) tp = s;
            else if (!tr) begin
                if (tp < s) tp = s;
            end else begin
                if (tp > s) tp = s;
            end
        end else if (is_neg) begin
            u.neg = 1'b1;
            if (!prev_neg) tp = s;
            else if (!tr) begin
                if (tp > s) tp = s;
            end else begin
                if (tp < s) tp = s;
            end
        end else begin
            tr = 1'b0;
            tp = s;
        end
        // Flick re-trigger against the tracked peak
        d_up = {{2{s[AXIS_W-1]}}, s} - {{2{tp[AXIS_W-1]}}, tp};
        d_dn = {{2{tp[AXIS_W-1]}}, tp} - {{2{s[AXIS_W-1]}}, s};
        m11  = {3'b000, margin};
        if (is_pos) begin
            if (tr && (d_up > m11)) begin
                u.pos = 1'b0;
                tr    = 1'b0;
            end
            if (d_dn > m11) tr = 1'b1;
        end else if (is_neg) begin
            if (tr && (d_dn > m11)) begin
                u.neg = 1'b0;
                tr    = 1'b0;
            end
            if (d_up > m11) tr = 1'b1;
        end
        u.peak    = tp;
        u.rebound = tr;
        return u;
    endfunction

    // Frame state
    logic [VEC_W-1:0]         r_prev;
    logic signed [AXIS_W-1:0] r_peak_x;
    logic signed [AXIS_W-1:0] r_peak_y;
    logic                     r_reb_x;
    logic                     r_reb_y;
    logic signed [8:0]        r_interval;
    logic [8:0]               r_delay;
    logic signed [8:0]        n_interval;
    logic [8:0]               n_delay;

    // Result register
    logic                     r_out_valid;
    logic [VEC_W-1:0]         r_cur;
    logic [VEC_W-1:0]         r_pressed;
    logic [VEC_W-1:0]         r_rep;
    logic signed [AXIS_W-1:0] r_sx;
    logic signed [AXIS_W-1:0] r_sy;

    t_axis_upd                upd_x;
    t_axis_upd                upd_y;
    logic [VEC_W-1:0]         cur;
    logic [VEC_W-1:0]         pressed;
    logic [VEC_W-1:0]         rep;
    logic signed [8:0]        int_dec;
    logic [8:0]               dly_dec;
    logic                     pop;

    // Take the next item whenever the result register is free or draining
    assign o_rd_ready = !r_out_valid || o_out.ready;
    assign pop        = i_rd_valid && o_rd_ready;

    assign upd_x = f_axis(i_rd_item.stick_x, i_rd_item.x_pos, i_rd_item.x_neg,
                          r_prev[BIT_RIGHT], r_prev[BIT_LEFT], r_peak_x, r_reb_x,
                          i_cfg.flick_margin);
    assign upd_y = f_axis(i_rd_item.stick_y, i_rd_item.y_pos, i_rd_item.y_neg,
                          r_prev[BIT_UP], r_prev[BIT_DOWN], r_peak_y, r_reb_y,
                          i_cfg.flick_margin);

    assign cur     = {upd_y.pos, upd_y.neg, upd_x.neg, upd_x.pos, i_rd_item.buttons};
    assign pressed = (cur ^ r_prev) & cur;
    assign int_dec = r_interval - 9'sd1;
    assign dly_dec = r_delay - 9'd1;

    // Typematic repeat
    always_comb begin
        n_interval = r_interval;
        n_delay    = r_delay;
        rep        = '0;
        priority if (cur == '0) begin
            rep = '0;
        end else if (r_prev != cur) begin
            rep        = pressed;
            n_interval = '1;
            n_delay    = {1'b0, i_cfg.repeat_delay};
        end else if (!r_interval[8]) begin
            n_interval = int_dec;
            if (int_dec == '0) begin
                rep        = cur;
                n_interval = {1'b0, i_cfg.repeat_interval};
            end
        end else begin
            n_delay = dly_dec;
            if (dly_dec == '0) begin
                rep        = cur;
                n_interval = {1'b0, i_cfg.repeat_interval};
            end
        end
    end

    // Update frame state on each taken item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_peak_x    <= '0;
            r_peak_y    <= '0;
            r_reb_x     <= 1'b0;
            r_reb_y     <= 1'b0;
            r_interval  <= '0;
            r_delay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_prev     <= cur;
                r_peak_x   <= upd_x.peak;
                r_peak_y   <= upd_y.peak;
                r_reb_x    <= upd_x.rebound;
                r_reb_y    <= upd_y.rebound;
                r_interval <= n_interval;
                r_delay    <= n_delay;
            end
            if (pop) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur     <= cur;
            r_pressed <= pressed;
            r_rep     <= rep;
            r_sx      <= i_rd_item.stick_x;
            r_sy      <= i_rd_item.stick_y;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.current_buttons = r_cur;
    assign o_out.pressed_buttons = r_pressed;
    assign o_out.repeat_buttons  = r_rep;
    assign o_out.stick_x_out     = r_sx;
    assign o_out.stick_y_out     = r_sy;

    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> r_out_valid)
        else $error("taken item did not reach the result register");

    a_rep_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_rep & ~r_cur) == '0))
        else $error("repeat bit set for a button not held");

    a_pressed_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_pressed & ~r_cur) == '0))
        else $error("press edge for a button not held");

    a_dir_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !((r_cur[BIT_RIGHT] && r_cur[BIT_LEFT]) ||
                          (r_cur[BIT_UP] && r_cur[BIT_DOWN])))
        else $error("opposite direction bits set together");

    a_interval_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_interval[8] |-> (r_interval == '1))
        else $error("interval counter below minus one");

endmodule

[rtl/core/gamepad_input_conditioner.sv]
// Gamepad input conditioner, top level: configuration registers and the
// front end, queue and back end. Depends on gic_pkg, gic_if and submodules.
//
// One pad sample request is accepted per clock cycle when the queue has room,
// and one result request leaves per sample. A sample is conditioned and
// classified in the cycle it is accepted and written into a two-entry queue;
// the back end takes it from the queue, updates the per-frame state and loads
// the result register in the same cycle. The back end's state update sets the
// sustained rate of one sample per cycle; backpressure on the result side
// fills the queue and then stalls the input. Configuration writes are always
// taken (ready is tied high) and must only be issued while the block is idle.
module gamepad_input_conditioner import gic_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gic_in_if.sink     i_in,
    gic_out_if.source  o_out,
    gic_cfg_if.sink    i_cfg
);

    t_cfg  r_cfg;
    logic  wr_valid;
    logic  wr_ready;
    t_item wr_item;
    logic  rd_valid;
    logic  rd_ready;
    t_item rd_item;

    // Write configuration registers; unknown indexes are dropped
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_REVERSE_ANALOG:      r_cfg.reverse_analog      <= i_cfg.data[0];
                CFG_DEAD_ZONE:           r_cfg.dead_zone           <= i_cfg.data[6:0];
                CFG_DIRECTION_THRESHOLD: r_cfg.direction_threshold <= i_cfg.data[6:0];
                CFG_FLICK_MARGIN:        r_cfg.flick_margin        <= i_cfg.data;
                CFG_REPEAT_DELAY:        r_cfg.repeat_delay        <= i_cfg.data;
                CFG_REPEAT_INTERVAL:     r_cfg.repeat_interval     <= i_cfg.data;
                default:                 r_cfg                     <= r_cfg;
            endcase
        end
    end

    gic_front u_front (
        .i_cfg      (r_cfg),
        .i_in       (i_in),
        .o_wr_valid (wr_valid),
        .i_wr_ready (wr_ready),
        .o_wr_item  (wr_item)
    );

    gic_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (wr_valid),
        .o_wr_ready (wr_ready),
        .i_wr_item  (wr_item),
        .o_rd_valid (rd_valid),
        .i_rd_ready (rd_ready),
        .o_rd_item  (rd_item)
    );

    gic_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_rd_valid (rd_valid),
        .o_rd_ready (rd_ready),
        .i_rd_item  (rd_item),
        .o_out      (o_out)
    );

endmodule

[verif/gamepad_input_conditioner_test.sv]
// Self-checking testbench for gamepad_input_conditioner: dead zone, direction bits,
// flick re-trigger, press edges and typematic repeat, checked against a local predictor.
// Depends on gic_pkg and the channel interfaces in gic_if.
`timescale 1ns / 100ps

module gamepad_input_conditioner_test;
    import gic_pkg::*;

    // Register indexes past the end of the map; writes to them must be dropped
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED_LO = 3'd6;
    localparam logic [CIDX_W-1:0] CFG_UNMAPPED_HI = 3'd7;

    typedef struct packed {
        logic [VEC_W-1:0]  current;
        logic [VEC_W-1:0]  pressed;
        logic [VEC_W-1:0]  repeated;
        logic [AXIS_W-1:0] stick_x;
        logic [AXIS_W-1:0] stick_y;
    } t_frame_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gic_in_if  in_if ();
    gic_out_if out_if ();
    gic_cfg_if cfg_if ();

    gamepad_input_conditioner uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor copy of the registers
    logic cfg_reverse;
    int   cfg_dead_zone;
    int   cfg_threshold;
    int   cfg_margin;
    int   cfg_delay;
    int   cfg_interval;

    // Predictor copy of the per-frame state
    logic [VEC_W-1:0] prev_buttons_q;
    int               peak_x_q;
    int               peak_y_q;
    logic             rebound_x_q;
    logic             rebound_y_q;
    int               interval_cnt_q;
    logic [8:0]       delay_cnt_q;

    t_frame_result expected_frames[$];
    int            mismatch_count = 0;
    bit            traffic_gaps = 1'b1;
    int            hold_len = 0;
    logic          receiver_hold = 1'b0;

    // Random stimulus walk state
    int walk_x = 0;
    int walk_y = 0;
    int held_buttons = 0;
    int run_left = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic reset_predictor();
        cfg_reverse    = CFG_RESET.reverse_analog;
        cfg_dead_zone  = int'(CFG_RESET.dead_zone);
        cfg_threshold  = int'(CFG_RESET.direction_threshold);
        cfg_margin     = int'(CFG_RESET.flick_margin);
        cfg_delay      = int'(CFG_RESET.repeat_delay);
        cfg_interval   = int'(CFG_RESET.repeat_interval);
        prev_buttons_q = '0;
        peak_x_q       = 0;
        peak_y_q       = 0;
        rebound_x_q    = 1'b0;
        rebound_y_q    = 1'b0;
        interval_cnt_q = 0;
        delay_cnt_q    = '0;
    endtask

    // Pull an axis toward zero by the dead zone, then apply reversal
    function automatic int shrink_axis(input logic [RAW_W-1:0] raw);
        int a;
        a = int'($signed(raw));
        if (a > 0) begin
            a = a - cfg_dead_zone;
            if (a < 0) a = 0;
        end else if (a < 0) begin
            a = a + cfg_dead_zone;
            if (a > 0) a = 0;
        end
        if (cfg_reverse) a = -a;
        return a;
    endfunction

    // Set the direction bit and follow the peak (or the trough while rebounding)
    function automatic logic [VEC_W-1:0] track_peak(input int s, inout int peak,
                                                    inout logic rebound,
                                                    input int pos_idx, input int neg_idx);
        logic [VEC_W-1:0] bits;
        bits = '0;
        if (s > cfg_threshold) begin
            bits[pos_idx] = 1'b1;
            if (!prev_buttons_q[pos_idx]) begin
                peak = s;
            end else if (!rebound) begin
                if (peak < s) peak = s;
            end else begin
                if (peak > s) peak = s;
            end
        end else if (s < -cfg_threshold) begin
            bits[neg_idx] = 1'b1;
            if (!prev_buttons_q[neg_idx]) begin
                peak = s;
            end else if (!rebound) begin
                if (peak > s) peak = s;
            end else begin
                if (peak < s) peak = s;
            end
        end else begin
            rebound = 1'b0;
            peak    = s;
        end
        return bits;
    endfunction

    // Arm on a pull-back past the margin, fire on the next push-out past it
    function automatic logic [VEC_W-1:0] flick_clear(input int s, input int peak,
                                                     inout logic rebound,
                                                     input int pos_idx, input int neg_idx);
        logic [VEC_W-1:0] clr;
        clr = '0;
        if (s > cfg_threshold) begin
            if (rebound && (s - peak > cfg_margin)) begin
                clr[pos_idx] = 1'b1;
                rebound      = 1'b0;
            end
            if (peak - s > cfg_margin) rebound = 1'b1;
        end else if (s < -cfg_threshold) begin
            if (rebound && (peak - s > cfg_margin)) begin
                clr[neg_idx] = 1'b1;
                rebound      = 1'b0;
            end
            if (s - peak > cfg_margin) rebound = 1'b1;
        end
        return clr;
    endfunction

    function automatic t_frame_result predict_frame(input logic [BTN_W-1:0] raw_btn,
                                                    input logic [RAW_W-1:0] raw_x,
                                                    input logic [RAW_W-1:0] raw_y);
        t_frame_result    r;
        int               sx;
        int               sy;
        logic [VEC_W-1:0] btn;
        logic [VEC_W-1:0] cur;
        logic [VEC_W-1:0] rep;
        sx  = shrink_axis(raw_x);
        sy  = shrink_axis(raw_y);
        btn = {{(VEC_W-BTN_W){1'b0}}, raw_btn};
        btn = btn | track_peak(sx, peak_x_q, rebound_x_q, BIT_RIGHT, BIT_LEFT);
        btn = btn | track_peak(sy, peak_y_q, rebound_y_q, BIT_UP, BIT_DOWN);
        btn = btn & ~flick_clear(sx, peak_x_q, rebound_x_q, BIT_RIGHT, BIT_LEFT);
        btn = btn & ~flick_clear(sy, peak_y_q, rebound_y_q, BIT_UP, BIT_DOWN);
        cur = btn;

        // Typematic repeat: initial delay, then fixed interval
        if (cur == '0) begin
            rep = '0;
        end else if (prev_buttons_q != cur) begin
            rep            = cur & ~prev_buttons_q;
            interval_cnt_q = -1;
            delay_cnt_q    = 9'(cfg_delay);
        end else if (interval_cnt_q >= 0) begin
            interval_cnt_q = interval_cnt_q - 1;
            if (interval_cnt_q != 0) begin
                rep = '0;
            end else begin
                rep            = cur;
                interval_cnt_q = cfg_interval;
            end
        end else begin
            delay_cnt_q = delay_cnt_q - 9'd1;
            if (delay_cnt_q != '0) begin
                rep = '0;
            end else begin
                rep            = cur;
                interval_cnt_q = cfg_interval;
            end
        end

        r.current  = cur;
        r.pressed  = cur & ~prev_buttons_q;
        r.repeated = rep;
        r.stick_x  = AXIS_W'(sx);
        r.stick_y  = AXIS_W'(sy);
        prev_buttons_q = cur;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers
    // ------------------------------------------------------------------
    task automatic log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Offer one pad sample request, hold it until taken, then predict it
    task automatic send_sample(input logic [BTN_W-1:0] buttons, input int x, input int y);
        logic [RAW_W-1:0] x_raw;
        logic [RAW_W-1:0] y_raw;
        int               gap;
        x_raw = x[RAW_W-1:0];
        y_raw = y[RAW_W-1:0];
        if (traffic_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.raw_buttons <= buttons;
        in_if.raw_stick_x <= x_raw;
        in_if.raw_stick_y <= y_raw;
        do @(posedge i_clk); while (!in_if.ready);
        expected_frames.push_back(predict_frame(buttons, x_raw, y_raw));
    endtask

    // Drop the input and wait until every result has come back
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register; valid stays up so writes can go back to back
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        case (idx)
            CFG_REVERSE_ANALOG:      cfg_reverse   = value[0];
            CFG_DEAD_ZONE:           cfg_dead_zone = int'(value[6:0]);
            CFG_DIRECTION_THRESHOLD: cfg_threshold = int'(value[6:0]);
            CFG_FLICK_MARGIN:        cfg_margin    = int'(value);
            CFG_REPEAT_DELAY:        cfg_delay     = int'(value);
            CFG_REPEAT_INTERVAL:     cfg_interval  = int'(value);
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int rev, input int dz, input int thr,
                                  input int margin, input int delay, input int interval);
        wait_drain();
        write_reg(CFG_REVERSE_ANALOG, CDATA_W'(rev));
        write_reg(CFG_DEAD_ZONE, CDATA_W'(dz));
        write_reg(CFG_DIRECTION_THRESHOLD, CDATA_W'(thr));
        write_reg(CFG_FLICK_MARGIN, CDATA_W'(margin));
        write_reg(CFG_REPEAT_DELAY, CDATA_W'(delay));
        write_reg(CFG_REPEAT_INTERVAL, CDATA_W'(interval));
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stalls
    // ------------------------------------------------------------------
    initial begin
        int            stall_left;
        t_frame_result seen;
        t_frame_result want;
        stall_left = 0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                seen.current  = out_if.current_buttons;
                seen.pressed  = out_if.pressed_buttons;
                seen.repeated = out_if.repeat_buttons;
                seen.stick_x  = out_if.stick_x_out;
                seen.stick_y  = out_if.stick_y_out;
                if (expected_frames.size() == 0) begin
                    log_failure($sformatf("unexpected result request: cur=%h x=%h y=%h",
                                          seen.current, seen.stick_x, seen.stick_y));
                end else begin
                    want = expected_frames.pop_front();
                    if (seen.current !== want.current || seen.pressed !== want.pressed ||
                        seen.repeated !== want.repeated || seen.stick_x !== want.stick_x ||
                        seen.stick_y !== want.stick_y) begin
                        log_failure($sformatf({"mismatch: exp cur=%h prs=%h rep=%h x=%h y=%h",
                                               " | got cur=%h prs=%h rep=%h x=%h y=%h"},
                                              want.current, want.pressed, want.repeated,
                                              want.stick_x, want.stick_y,
                                              seen.current, seen.pressed, seen.repeated,
                                              seen.stick_x, seen.stick_y));
                    end
                end
            end
            // Hold off during reset, a long hold, or a random stall burst
            if (!i_rst_n || receiver_hold) begin
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else if (traffic_gaps && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 7);
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // Long receiver hold, counted here in cycles
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_len > 0) begin
                receiver_hold <= 1'b1;
                repeat (hold_len) @(posedge i_clk);
                receiver_hold <= 1'b0;
                hold_len = 0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values: field extremes, dead zone edge, threshold edge, delay then interval
    task automatic test_reset_defaults();
        send_sample(16'h0000, 0, 0);
        send_sample(16'hFFFF, 127, -128);
        send_sample(16'hFFFF, 127, -128);
        send_sample(16'h5555, 4, -4);
        send_sample(16'hAAAA, -128, 127);
        send_sample(16'h0001, 37, -36);
        repeat (20) send_sample(16'h8000, 5, -5);
    endtask

    // Register extremes, zero threshold, masked writes and unmapped indexes
    task automatic test_register_extremes();
        apply_settings(1, 0, 0, 0, 1, 1);
        send_sample(16'h0000, 0, 0);
        send_sample(16'h0000, 1, -1);
        send_sample(16'h0010, -128, 127);
        repeat (4) send_sample(16'h0010, -128, 127);
        send_sample(16'h0000, 0, 1);

        apply_settings(0, 127, 127, 255, 255, 255);
        send_sample(16'h0200, -128, 127);
        send_sample(16'h0200, 127, -128);
        send_sample(16'h0000, -127, 126);

        // Masked data, then writes that must leave every register alone
        wait_drain();
        write_reg(CFG_REVERSE_ANALOG, 8'hFE);
        write_reg(CFG_DEAD_ZONE, 8'hFF);
        write_reg(CFG_DIRECTION_THRESHOLD, 8'h85);
        write_reg(CFG_UNMAPPED_LO, 8'h00);
        write_reg(CFG_UNMAPPED_HI, 8'hFF);
        cfg_if.valid <= 1'b0;
        send_sample(16'h0400, -128, 127);
        send_sample(16'h0400, 40, -40);
        send_sample(16'h0400, 0, 0);
    endtask

    // Stick out, pull back past the margin, push out again: bit drops one frame
    task automatic test_flick_retrigger();
        int flick_path [14] = '{100, 70, 110, 70, 110, 60, 110, 0,
                                -100, -70, -110, -70, -110, 0};
        for (int rev = 0; rev < 2; rev++) begin
            apply_settings(rev, 4, 32, 16, 15, 4);
            foreach (flick_path[i]) send_sample(16'h0000, flick_path[i], flick_path[i]);
            foreach (flick_path[i]) send_sample(16'h0020, flick_path[i], -flick_path[i]);
        end
    endtask

    // Zero delay wraps the counter; zero interval falls back to the delay count
    task automatic test_repeat_corners();
        apply_settings(0, 4, 32, 16, 0, 4);
        repeat (518) send_sample(16'h0002, 0, 0);
        repeat (5) send_sample(16'h0000, 10, -10);
        apply_settings(0, 4, 32, 16, 2, 0);
        repeat (12) send_sample(16'h0004, 0, 0);
    endtask

    // Receiver holds off while samples keep coming: queue fills, input stalls
    task automatic test_backpressure();
        apply_settings(0, 2, 20, 8, 3, 2);
        traffic_gaps = 1'b0;
        hold_len = 60;
        for (int i = 0; i < 30; i++) send_sample(16'(i / 4), 25 + i * 3, -25 - i * 3);
        wait_drain();
        traffic_gaps = 1'b1;
    endtask

    function automatic int next_axis(input int v);
        int n;
        n = v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = v;
            4, 5, 6, 7: n = v + int'($urandom_range(0, 90)) - 45;
            8:          n = int'($urandom_range(0, 255)) - 128;
            default:    n = 0;
        endcase
        if (n > 127) n = 127;
        if (n < -128) n = -128;
        return n;
    endfunction

    // Held buttons with random run lengths and sweeping sticks
    task automatic play_random_frames(input int count);
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                case ($urandom_range(0, 4))
                    0: held_buttons = 0;
                    1: held_buttons = $urandom_range(0, 16'hFFFF);
                    2: held_buttons = 1 << $urandom_range(0, BTN_W - 1);
                    3: held_buttons = 16'hFFFF;
                    default: held_buttons = held_buttons ^ (1 << $urandom_range(0, BTN_W - 1));
                endcase
                run_left = $urandom_range(1, 30);
            end
            run_left--;
            walk_x = next_axis(walk_x);
            walk_y = next_axis(walk_y);
            send_sample(BTN_W'(held_buttons), walk_x, walk_y);
        end
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 6; phase++) begin
            traffic_gaps = (phase != 1 && phase != 5);
            if ($urandom_range(0, 3) == 0) begin
                apply_settings($urandom_range(0, 1), $urandom_range(0, 127),
                               $urandom_range(0, 127), $urandom_range(0, 255),
                               $urandom_range(1, 255), $urandom_range(1, 255));
            end else begin
                apply_settings($urandom_range(0, 1), $urandom_range(0, 20),
                               $urandom_range(0, 60), $urandom_range(0, 40),
                               $urandom_range(1, 6), $urandom_range(1, 4));
            end
            play_random_frames(24);
            // Sender pauses until every outstanding result is back
            if (phase == 2) wait_drain();
            play_random_frames(24);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.raw_buttons <= '0;
        in_if.raw_stick_x <= '0;
        in_if.raw_stick_y <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.index      <= '0;
        cfg_if.data       <= '0;
        reset_predictor();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_flick_retrigger();
        test_repeat_corners();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
